// ===== hw/rtl/apsd_pkg.sv =====
`timescale 1ns / 1ps

package apsd_pkg;

  // Sizing
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int PEAK_W       = 32;
  localparam int LVL_W        = 17;
  localparam int FRAC_BITS    = 16;
  localparam int SUM_W        = LVL_W + CNT_W;
  localparam int STEP_W       = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;

  // Q1.16 unity
  localparam logic [LVL_W-1:0] Q_ONE = LVL_W'(1 << FRAC_BITS);

  // Register reset values
  localparam logic [3:0]       CHANNELS_RST  = 4'd1;
  localparam logic [LVL_W-1:0] THRESHOLD_RST = 17'd2949;
  localparam logic [15:0]      HOLD_RST      = 16'd1500;

  typedef enum logic [2:0] {
    FMT_S8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_U8  = 3'd3,
    FMT_U16 = 3'd4,
    FMT_U32 = 3'd5
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT    = 2'd0,
    CFG_CHANNELS  = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_HOLD      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_STOP   = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_NRD,
    ST_NLD,
    ST_NCHK,
    ST_NDIV,
    ST_NACC,
    ST_ADIV,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic              cmd;
    logic [PEAK_W-1:0] sample;
    logic              last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [LVL_W-1:0] average_level;
    logic [LVL_W-1:0] highest_level;
    logic             timer_running;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [PEAK_W-1:0] rem_init;
    logic [SUM_W-1:0]  dividend;
    logic [PEAK_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/apsd_ram.sv =====
`timescale 1ns / 1ps

module apsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/apsd_div.sv =====
`timescale 1ns / 1ps

module apsd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  apsd_pkg::div_req_t  req,
  output apsd_pkg::div_rsp_t  rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [apsd_pkg::STEP_W-1:0]       cnt_r;
  logic [apsd_pkg::PEAK_W-1:0]       rem_r;
  logic [apsd_pkg::SUM_W-1:0]        dvd_r;
  logic [apsd_pkg::PEAK_W-1:0]       dsr_r;
  logic [apsd_pkg::SUM_W-1:0]        q_r;

  logic [apsd_pkg::PEAK_W:0]         trial;
  logic                              fits;
  logic [apsd_pkg::PEAK_W-1:0]       rem_step;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, dvd_r[apsd_pkg::SUM_W-1]};
    fits     = (trial >= {1'b0, dsr_r});
    rem_step = fits ? apsd_pkg::PEAK_W'(trial - {1'b0, dsr_r})
                    : trial[apsd_pkg::PEAK_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == apsd_pkg::STEP_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: load on start, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      cnt_r <= req.steps;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[apsd_pkg::SUM_W-2:0], 1'b0};
      q_r   <= {q_r[apsd_pkg::SUM_W-2:0], fits};
      cnt_r <= cnt_r - apsd_pkg::STEP_W'(1);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// ===== hw/rtl/audio_peak_silence_detector_core.sv =====
`timescale 1ns / 1ps

// Peak level meter with silence timeout.
// Input channel (in_valid / in_stall / in_data): one item per transfer, either an
// interleaved PCM sample (channel taken from an internal rotating position) or a
// timer tick. Result channel (out_valid / out_stall / out_data): buffer level
// reports on the sample marked last_of_buffer, stop requests when the silence
// timer expires. Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// always ready; write only while the block is idle.
// A plain sample reads its stored peak from memory, then writes the larger value back.
// A tick's stop request is registered and appears in out_data the next cycle.
// A last sample then normalises every channel in turn (the normalisation
// divider produces one quotient bit per cycle, 16 bits per channel) and runs
// the averaging division, then the report is registered once the output slot is free.
// At reset the control registers take their documented values; the peak memory is not
// swept, per-channel valid flags make unwritten peaks read as zero.
// While the receiver stalls, one result is held in the output register; the block
// takes no new item until that register is free or being drained.

module audio_peak_silence_detector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  apsd_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output apsd_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CH_W   = apsd_pkg::CH_W;
  localparam int CNT_W  = apsd_pkg::CNT_W;
  localparam int PEAK_W = apsd_pkg::PEAK_W;
  localparam int LVL_W  = apsd_pkg::LVL_W;
  localparam int SUM_W  = apsd_pkg::SUM_W;

  // Sample magnitude per format
  function automatic logic [PEAK_W-1:0] magnitude(apsd_pkg::fmt_t fmt,
                                                  logic [PEAK_W-1:0] raw);
    logic [PEAK_W-1:0] m;
    m = '0;
    case (fmt)
      apsd_pkg::FMT_S8:
        m = raw[7] ? PEAK_W'(9'h100 - {1'b0, raw[7:0]}) : PEAK_W'(raw[7:0]);
      apsd_pkg::FMT_S16:
        m = raw[15] ? PEAK_W'(17'h10000 - {1'b0, raw[15:0]}) : PEAK_W'(raw[15:0]);
      apsd_pkg::FMT_S32:
        m = raw[31] ? (PEAK_W'(0) - raw) : raw;
      apsd_pkg::FMT_U8:  m = PEAK_W'(raw[7:0]);
      apsd_pkg::FMT_U16: m = PEAK_W'(raw[15:0]);
      apsd_pkg::FMT_U32: m = raw;
      default:           m = '0;
    endcase
    return m;
  endfunction

  // Full-scale value per format
  function automatic logic [PEAK_W-1:0] full_scale(apsd_pkg::fmt_t fmt);
    logic [PEAK_W-1:0] f;
    f = PEAK_W'(1);
    case (fmt)
      apsd_pkg::FMT_S8:  f = PEAK_W'(127);
      apsd_pkg::FMT_S16: f = PEAK_W'(32767);
      apsd_pkg::FMT_S32: f = 32'h7FFF_FFFF;
      apsd_pkg::FMT_U8:  f = PEAK_W'(255);
      apsd_pkg::FMT_U16: f = PEAK_W'(65535);
      apsd_pkg::FMT_U32: f = 32'hFFFF_FFFF;
      default:           f = PEAK_W'(1);
    endcase
    return f;
  endfunction

  // Control state
  apsd_pkg::st_t               state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [apsd_pkg::MAX_CHANNELS-1:0] pvalid_r, pvalid_nxt;
  logic [CH_W-1:0]             pos_r, pos_nxt;
  logic [LVL_W-1:0]            highest_r, highest_nxt;
  logic [15:0]                 ticks_r, ticks_nxt;
  logic                        active_r, active_nxt;
  apsd_pkg::fmt_t              fmt_r, fmt_nxt;
  logic [3:0]                  chan_cfg_r, chan_cfg_nxt;
  logic [LVL_W-1:0]            thr_r, thr_nxt;
  logic [15:0]                 hold_r, hold_nxt;

  // Payload
  logic [PEAK_W-1:0]           mag_r, mag_nxt;
  logic [CH_W-1:0]             wpos_r, wpos_nxt;
  logic                        last_r, last_nxt;
  logic [CH_W-1:0]             idx_r, idx_nxt;
  logic [PEAK_W:0]             num_r, num_nxt;
  logic [LVL_W-1:0]            level_r, level_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [LVL_W-1:0]            avg_r, avg_nxt;
  apsd_pkg::out_item_t         out_data_r, out_data_nxt;

  // Memory and divider
  logic                        ram_we;
  logic [CH_W-1:0]             ram_raddr;
  logic [PEAK_W-1:0]           ram_wdata;
  logic [PEAK_W-1:0]           ram_rdata;
  apsd_pkg::div_req_t          div_req;
  apsd_pkg::div_rsp_t          div_rsp;

  // Derived
  logic [CNT_W-1:0]            chans;
  logic [CH_W-1:0]             pos_sel;
  logic                        slot_free;
  logic                        in_xfer;
  logic [PEAK_W-1:0]           full;
  logic                        fmt_ok;
  logic                        fmt_unsigned;

  apsd_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (apsd_pkg::MAX_CHANNELS)
  ) u_peak_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  apsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Effective channel count and write position
  always_comb begin
    if (chan_cfg_r == 4'd0) begin
      chans = CNT_W'(1);
    end else if (int'(chan_cfg_r) > apsd_pkg::MAX_CHANNELS) begin
      chans = CNT_W'(apsd_pkg::MAX_CHANNELS);
    end else begin
      chans = CNT_W'(chan_cfg_r);
    end
    pos_sel      = (CNT_W'(pos_r) >= chans) ? '0 : pos_r;
    full         = full_scale(fmt_r);
    fmt_ok       = fmt_r inside {apsd_pkg::FMT_S8, apsd_pkg::FMT_S16, apsd_pkg::FMT_S32,
                                 apsd_pkg::FMT_U8, apsd_pkg::FMT_U16, apsd_pkg::FMT_U32};
    fmt_unsigned = fmt_r inside {apsd_pkg::FMT_U8, apsd_pkg::FMT_U16, apsd_pkg::FMT_U32};
  end

  // Handshakes
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == apsd_pkg::ST_IDLE) && slot_free);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ram_raddr = (state_r == apsd_pkg::ST_IDLE) ? pos_sel : idx_r;

  // Next state and datapath
  always_comb begin
    logic [PEAK_W-1:0] peak;
    logic [PEAK_W:0]   twice;
    logic [15:0]       dec;
    logic [LVL_W-1:0]  hi_new;
    logic              act_new;
    logic [CNT_W-1:0]  pos_inc;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    pvalid_nxt    = pvalid_r;
    pos_nxt       = pos_r;
    highest_nxt   = highest_r;
    ticks_nxt     = ticks_r;
    active_nxt    = active_r;
    fmt_nxt       = fmt_r;
    chan_cfg_nxt  = chan_cfg_r;
    thr_nxt       = thr_r;
    hold_nxt      = hold_r;
    mag_nxt       = mag_r;
    wpos_nxt      = wpos_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    num_nxt       = num_r;
    level_nxt     = level_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wdata     = mag_r;
    div_req       = '0;
    peak          = '0;
    twice         = '0;
    dec           = '0;
    hi_new        = highest_r;
    act_new       = active_r;
    pos_inc       = '0;

    // Configuration writes
    if (cfg_valid && cfg_ready) begin
      case (apsd_pkg::cfg_idx_t'(cfg_index))
        apsd_pkg::CFG_FORMAT:    fmt_nxt      = apsd_pkg::fmt_t'(cfg_data[2:0]);
        apsd_pkg::CFG_CHANNELS:  chan_cfg_nxt = cfg_data[3:0];
        apsd_pkg::CFG_THRESHOLD: thr_nxt      = cfg_data[LVL_W-1:0];
        apsd_pkg::CFG_HOLD:      hold_nxt     = cfg_data[15:0];
        default: ;
      endcase
    end

    case (state_r)
      // Take a sample or a tick
      apsd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.cmd == apsd_pkg::CMD_TICK) begin
            if (active_r) begin
              dec = (ticks_r != 16'd0) ? (ticks_r - 16'd1) : 16'd0;
              if (dec != 16'd0) begin
                ticks_nxt = dec;
              end else begin
                ticks_nxt     = 16'd0;
                active_nxt    = 1'b0;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind:          apsd_pkg::KIND_STOP,
                                  average_level: '0,
                                  highest_level: highest_r,
                                  timer_running: 1'b0};
              end
            end
          end else begin
            mag_nxt   = magnitude(fmt_r, in_data.sample);
            wpos_nxt  = pos_sel;
            last_nxt  = in_data.last_of_buffer;
            state_nxt = apsd_pkg::ST_UPD;
          end
        end
      end

      // Write back the larger of stored peak and new magnitude
      apsd_pkg::ST_UPD: begin
        peak               = pvalid_r[wpos_r] ? ram_rdata : '0;
        ram_we             = 1'b1;
        ram_wdata          = (mag_r > peak) ? mag_r : peak;
        pvalid_nxt[wpos_r] = 1'b1;
        pos_inc            = CNT_W'(wpos_r) + CNT_W'(1);
        pos_nxt            = (pos_inc >= chans) ? '0 : CH_W'(pos_inc);
        if (last_r) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = apsd_pkg::ST_NRD;
        end else begin
          state_nxt = apsd_pkg::ST_IDLE;
        end
      end

      // Read address for the channel being normalised is presented here
      apsd_pkg::ST_NRD: begin
        state_nxt = apsd_pkg::ST_NLD;
      end

      // Form the normalisation numerator
      apsd_pkg::ST_NLD: begin
        peak  = pvalid_r[idx_r] ? ram_rdata : '0;
        twice = {peak, 1'b0};
        if (fmt_unsigned) begin
          num_nxt = (twice >= {1'b0, full}) ? (twice - {1'b0, full})
                                            : ({1'b0, full} - twice);
        end else begin
          num_nxt = {1'b0, peak};
        end
        state_nxt = apsd_pkg::ST_NCHK;
      end

      // Saturate, zero, or hand off to the divider
      apsd_pkg::ST_NCHK: begin
        if (!fmt_ok) begin
          level_nxt = '0;
          state_nxt = apsd_pkg::ST_NACC;
        end else if (num_r >= {1'b0, full}) begin
          level_nxt = apsd_pkg::Q_ONE;
          state_nxt = apsd_pkg::ST_NACC;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = num_r[PEAK_W-1:0];
          div_req.dividend = '0;
          div_req.divisor  = full;
          div_req.steps    = apsd_pkg::STEP_W'(apsd_pkg::FRAC_BITS);
          state_nxt        = apsd_pkg::ST_NDIV;
        end
      end

      apsd_pkg::ST_NDIV: begin
        if (div_rsp.done) begin
          level_nxt = div_rsp.quotient[LVL_W-1:0];
          state_nxt = apsd_pkg::ST_NACC;
        end
      end

      // Accumulate and advance to the next channel or the average
      apsd_pkg::ST_NACC: begin
        sum_nxt = sum_r + SUM_W'(level_r);
        if (CNT_W'(idx_r) == (chans - CNT_W'(1))) begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = sum_nxt;
          div_req.divisor  = PEAK_W'(chans);
          div_req.steps    = apsd_pkg::STEP_W'(SUM_W);
          state_nxt        = apsd_pkg::ST_ADIV;
        end else begin
          idx_nxt   = idx_r + CH_W'(1);
          state_nxt = apsd_pkg::ST_NRD;
        end
      end

      apsd_pkg::ST_ADIV: begin
        if (div_rsp.done) begin
          avg_nxt   = div_rsp.quotient[LVL_W-1:0];
          state_nxt = apsd_pkg::ST_EMIT;
        end
      end

      // Update highest level and timer, clear peaks, issue the report
      apsd_pkg::ST_EMIT: begin
        if (slot_free) begin
          hi_new = (avg_r > highest_r) ? avg_r : highest_r;
          if (avg_r <= thr_r) begin
            act_new = 1'b1;
            if (!active_r) begin
              ticks_nxt = (hold_r == 16'd0) ? 16'd1 : hold_r;
            end
          end else begin
            act_new   = 1'b0;
            ticks_nxt = 16'd0;
          end
          highest_nxt   = hi_new;
          active_nxt    = act_new;
          pvalid_nxt    = '0;
          pos_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind:          apsd_pkg::KIND_REPORT,
                            average_level: avg_r,
                            highest_level: hi_new,
                            timer_running: act_new};
          state_nxt     = apsd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = apsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pvalid_r    <= '0;
      pos_r       <= '0;
      highest_r   <= '0;
      ticks_r     <= '0;
      active_r    <= 1'b0;
      fmt_r       <= apsd_pkg::FMT_S16;
      chan_cfg_r  <= apsd_pkg::CHANNELS_RST;
      thr_r       <= apsd_pkg::THRESHOLD_RST;
      hold_r      <= apsd_pkg::HOLD_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pvalid_r    <= pvalid_nxt;
      pos_r       <= pos_nxt;
      highest_r   <= highest_nxt;
      ticks_r     <= ticks_nxt;
      active_r    <= active_nxt;
      fmt_r       <= fmt_nxt;
      chan_cfg_r  <= chan_cfg_nxt;
      thr_r       <= thr_nxt;
      hold_r      <= hold_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    wpos_r     <= wpos_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    num_r      <= num_nxt;
    level_r    <= level_nxt;
    sum_r      <= sum_nxt;
    avg_r      <= avg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
